[src/assert_macros.svh]
// Assertion macros for the servo frame sweeper checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted
`define SFS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define SFS_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sfs_pkg.sv]
// Shared types, constants and helpers for the servo frame sweeper.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfs_pkg;

	// Field widths
	localparam int OP_W    = 1;
	localparam int YAW_W   = 13;
	localparam int MODE_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int REG_W   = 8;
	localparam int ANGLE_W = 8;
	localparam int APB_W   = 32;
	localparam int ADDR_W  = 3;

	localparam int DEFAULT_YAW_FRAC_BITS = 4;

	// Frame bytes and angle constants
	localparam logic [BYTE_W-1:0]  FRAME_START = 8'h24;
	localparam logic [BYTE_W-1:0]  FRAME_END   = 8'h23;
	localparam logic [BYTE_W-1:0]  DIGIT_BASE  = 8'd48;
	localparam logic [BYTE_W-1:0]  SERVO_BASE  = 8'd64;
	localparam logic [ANGLE_W-1:0] YAW_CENTER  = 8'd90;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;

	// Register reset values and indexes
	localparam logic [REG_W-1:0] HOLD_RESET   = 8'd30;
	localparam logic [REG_W-1:0] PERIOD_RESET = 8'd60;
	localparam logic REG_HOLD   = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

	// Operation and mode codes
	localparam logic [OP_W-1:0]   OP_TICK    = 1'b0;
	localparam logic [OP_W-1:0]   OP_INIT    = 1'b1;
	localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SWEEP = 2'd1;

	typedef struct packed {
		logic [REG_W-1:0] hold;
		logic [REG_W-1:0] period;
	} cfg_t;

	typedef struct packed {
		logic       hund;
		logic [3:0] tens;
		logic [3:0] units;
	} digits_t;

	// One burst: yaw digits for servos 1 and 3, 180-or-0 flags for servos 5 and 7
	typedef struct packed {
		digits_t yaw;
		logic    s5_hi;
		logic    s7_hi;
	} desc_t;

	// Split an angle of 0..180 into decimal digits (reciprocal multiply for tens)
	function automatic digits_t to_digits(input logic [ANGLE_W-1:0] a);
		digits_t    d;
		logic [6:0] rem;
		logic [14:0] prod;
		d.hund  = (a >= 8'd100);
		rem     = d.hund ? 7'(a - 8'd100) : 7'(a);
		prod    = 15'(rem) * 15'd205;
		d.tens  = prod[14:11];
		d.units = 4'(rem - 7'(d.tens) * 7'd10);
		return d;
	endfunction

endpackage

`default_nettype wire

[src/sfs_front.sv]
// Front end: accepts items, updates the wiper counter and builds a burst descriptor.
// Depends on sfs_pkg.
`default_nettype none

module sfs_front
	import sfs_pkg::*;
#(
	parameter int YAW_FRAC_BITS = DEFAULT_YAW_FRAC_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [OP_W-1:0]          op,
	input  wire logic signed [YAW_W-1:0]  yaw_q4,
	input  wire logic [MODE_W-1:0]        clean_mode,
	input  wire cfg_t                     cfg,
	output logic                          q_push,
	input  wire logic                     q_full,
	output desc_t                         q_desc
);

	localparam int FXW = (YAW_W > ANGLE_W + YAW_FRAC_BITS) ? YAW_W : ANGLE_W + YAW_FRAC_BITS;
	localparam int VW  = FXW + 2;
	localparam logic signed [VW-1:0] CENTER_FX = VW'(YAW_CENTER) <<< YAW_FRAC_BITS;

	logic                 accept;
	logic signed [VW-1:0] v;
	logic signed [VW-1:0] v_sh;
	logic [ANGLE_W-1:0]   angle;
	logic [REG_W-1:0]     count_base;
	logic [REG_W-1:0]     count_nxt;
	logic                 up_nxt;

	logic                 valid_s1;
	logic [ANGLE_W-1:0]   angle_s1;
	logic                 s5_hi_s1;
	logic                 s7_hi_s1;

	logic [REG_W-1:0]     sweep_count_q;
	logic                 wiper_up_q;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;

	// Yaw angle: trunc(90 - yaw), clamped to 0..180
	assign v    = CENTER_FX - {{(VW-YAW_W){yaw_q4[YAW_W-1]}}, yaw_q4};
	assign v_sh = v >>> YAW_FRAC_BITS;
	always_comb begin
		if (v[VW-1]) begin
			angle = '0;
		end else if (v_sh > VW'(ANGLE_MAX)) begin
			angle = ANGLE_MAX;
		end else begin
			angle = v_sh[ANGLE_W-1:0];
		end
	end

	// Wiper counter: sweep below hold, wrap at period, idle mode clears, others hold
	always_comb begin
		count_base = sweep_count_q;
		count_nxt  = sweep_count_q;
		up_nxt     = wiper_up_q;
		case (clean_mode)
			MODE_SWEEP: begin
				if (sweep_count_q >= cfg.hold) begin
					up_nxt = 1'b0;
					if (sweep_count_q >= cfg.period) begin
						count_base = '0;
					end
				end else begin
					up_nxt = 1'b1;
				end
				count_nxt = count_base + 8'd1;
			end
			MODE_IDLE: begin
				up_nxt    = 1'b0;
				count_nxt = '0;
			end
			default: begin
				up_nxt    = wiper_up_q;
				count_nxt = sweep_count_q;
			end
		endcase
	end

	// Advance sweep state on every accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_count_q <= '0;
			wiper_up_q    <= 1'b0;
		end else if (accept && op == OP_TICK) begin
			sweep_count_q <= count_nxt;
			wiper_up_q    <= up_nxt;
		end
	end

	// Stage 1: hold the clamped angle and wiper flags until the queue takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (op == OP_INIT) begin
				angle_s1 <= '0;
				s5_hi_s1 <= 1'b1;
				s7_hi_s1 <= 1'b1;
			end else begin
				angle_s1 <= angle;
				s5_hi_s1 <= up_nxt;
				s7_hi_s1 <= !up_nxt;
			end
		end
	end

	// Split into digits on the way into the queue
	assign q_push       = valid_s1;
	assign q_desc.yaw   = to_digits(angle_s1);
	assign q_desc.s5_hi = s5_hi_s1;
	assign q_desc.s7_hi = s7_hi_s1;

endmodule

`default_nettype wire

[src/sfs_queue.sv]
// Two-entry descriptor queue between front end and frame serialiser.
// Depends on sfs_pkg.
`default_nettype none

module sfs_queue
	import sfs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire desc_t wr_desc,
	output logic       q_full,
	input  wire logic  rd_en,
	output logic       q_empty,
	output desc_t      rd_desc
);

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_desc = mem_q[rd_ptr_q];

	// Store an entry on each write
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[src/sfs_back.sv]
// Frame serialiser: turns each descriptor into four 6-byte ASCII frames.
// Depends on sfs_pkg.
`default_nettype none

module sfs_back
	import sfs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire desc_t              q_desc,
	output logic                    q_pop,
	output logic                    empty,
	input  wire logic               pop,
	output logic [BYTE_W-1:0]       tx_byte,
	output logic                    last
);

	localparam logic [2:0] POS_START = 3'd0;
	localparam logic [2:0] POS_ID    = 3'd1;
	localparam logic [2:0] POS_HUND  = 3'd2;
	localparam logic [2:0] POS_TENS  = 3'd3;
	localparam logic [2:0] POS_UNITS = 3'd4;
	localparam logic [2:0] POS_END   = 3'd5;
	localparam logic [1:0] FRAME_LAST = 2'd3;

	desc_t             cur_q;
	logic              cur_valid_q;
	logic [1:0]        frame_q;
	logic [2:0]        pos_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;

	logic              out_free;
	logic              emit;
	logic              burst_end;
	logic              take;
	digits_t           dig;
	logic [BYTE_W-1:0] byte_nxt;

	assign out_free  = !out_valid_q || pop;
	assign emit      = cur_valid_q && out_free;
	assign burst_end = (frame_q == FRAME_LAST) && (pos_q == POS_END);
	assign take      = !q_empty && (!cur_valid_q || (emit && burst_end));
	assign q_pop     = take;

	// Pick the angle digits of the current frame
	always_comb begin
		case (frame_q)
			2'd0, 2'd1: dig = cur_q.yaw;
			2'd2:       dig = cur_q.s5_hi ? to_digits(ANGLE_MAX) : to_digits('0);
			default:    dig = cur_q.s7_hi ? to_digits(ANGLE_MAX) : to_digits('0);
		endcase
	end

	// Byte of the current frame position
	always_comb begin
		case (pos_q)
			POS_START: byte_nxt = FRAME_START;
			POS_ID:    byte_nxt = SERVO_BASE + {5'b0, frame_q, 1'b1};
			POS_HUND:  byte_nxt = DIGIT_BASE + {7'b0, dig.hund};
			POS_TENS:  byte_nxt = DIGIT_BASE + {4'b0, dig.tens};
			POS_UNITS: byte_nxt = DIGIT_BASE + {4'b0, dig.units};
			POS_END:   byte_nxt = FRAME_END;
			default:   byte_nxt = FRAME_END;
		endcase
	end

	// Load a descriptor and step through its 24 bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			frame_q     <= '0;
			pos_q       <= POS_START;
		end else if (take) begin
			cur_valid_q <= 1'b1;
			frame_q     <= '0;
			pos_q       <= POS_START;
		end else if (emit) begin
			if (burst_end) begin
				cur_valid_q <= 1'b0;
			end
			if (pos_q == POS_END) begin
				pos_q   <= POS_START;
				frame_q <= frame_q + 2'd1;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= q_desc;
		end
	end

	// Output register: hold the byte until it is popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= byte_nxt;
			last_q <= burst_end;
		end
	end

	assign empty   = !out_valid_q;
	assign tx_byte = byte_q;
	assign last    = last_q;

endmodule

`default_nettype wire

[src/servo_ascii_frame_sweeper.sv]
// Top level of the servo frame sweeper: configuration registers and the three parts.
// Depends on sfs_pkg, sfs_front, sfs_queue and sfs_back.
//
// Channel   Handshake                 Payload
// input     push / full               op, yaw_q4, clean_mode
// result    empty / pop               tx_byte, last (24 per item)
// config    psel penable pwrite       paddr, pwdata, prdata (hold at 0x0, period at 0x4)
//
// Each item yields 24 result transactions, one per cycle from the frame serialiser with
// pop held high; items follow back to back while the queue holds the next one.
// After acceptance the first byte passes stage 1, queue, burst and output registers.
// The front end takes further items while a burst streams out, until the two-entry
// queue and stage 1 are full. Reset clears counters, pointers, valid flags and the wiper
// state and loads the register defaults; data registers are left as they are.
`default_nettype none

module servo_ascii_frame_sweeper
	import sfs_pkg::*;
#(
	parameter int YAW_FRAC_BITS = DEFAULT_YAW_FRAC_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [OP_W-1:0]         op,
	input  wire logic signed [YAW_W-1:0] yaw_q4,
	input  wire logic [MODE_W-1:0]       clean_mode,
	output logic                         empty,
	input  wire logic                    pop,
	output logic [BYTE_W-1:0]            tx_byte,
	output logic                         last,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [ADDR_W-1:0]       paddr,
	input  wire logic [APB_W-1:0]        pwdata,
	output logic [APB_W-1:0]             prdata,
	output logic                         pready
);

	cfg_t  cfg_q;
	logic  cfg_wr;
	logic  q_push;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	desc_t push_desc;
	desc_t head_desc;

	// Configuration writes complete in the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold   <= HOLD_RESET;
			cfg_q.period <= PERIOD_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_HOLD:   cfg_q.hold   <= pwdata[REG_W-1:0];
				REG_PERIOD: cfg_q.period <= pwdata[REG_W-1:0];
				default:    cfg_q.hold   <= cfg_q.hold;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_PERIOD) ? APB_W'(cfg_q.period) : APB_W'(cfg_q.hold);

	sfs_front #(
		.YAW_FRAC_BITS(YAW_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op        (op),
		.yaw_q4    (yaw_q4),
		.clean_mode(clean_mode),
		.cfg       (cfg_q),
		.q_push    (q_push),
		.q_full    (q_full),
		.q_desc    (push_desc)
	);

	sfs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_desc(push_desc),
		.q_full (q_full),
		.rd_en  (q_pop),
		.q_empty(q_empty),
		.rd_desc(head_desc)
	);

	sfs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_desc (head_desc),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.tx_byte(tx_byte),
		.last   (last)
	);

endmodule

`default_nettype wire

[src/sfs_checker.sv]
// Port-level checker for the servo frame sweeper, bound to the top level.
// Depends on sfs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfs_checker
	import sfs_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              empty,
	input wire logic              pop,
	input wire logic [BYTE_W-1:0] tx_byte,
	input wire logic              last,
	input wire logic              pready
);

	// Burst ends on a frame terminator
	`SFS_ASSERT(a_last_is_end, clk, arst_n, (!empty && last) |-> (tx_byte == FRAME_END), "last byte is not a frame terminator")

	// A frame start never closes a burst
	`SFS_ASSERT(a_start_not_last, clk, arst_n, (!empty && tx_byte == FRAME_START) |-> !last, "frame start marked as last")

	// A waiting result holds until it is popped
	`SFS_ASSERT(a_out_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(tx_byte) && $stable(last)), "stalled result changed")

	// Configuration port never inserts wait states
	`SFS_ASSERT_NR(a_pready_high, clk, pready, "pready dropped")

endmodule

bind servo_ascii_frame_sweeper sfs_checker u_sfs_checker (.*);

`default_nettype wire
